>>> sv/indexed_ordered_list_unit_defines.svh
// Assertion macros for the indexed ordered list unit.
// Included by the top level; expects clk and rst_n in scope.
`ifndef INDEXED_ORDERED_LIST_UNIT_DEFINES_SVH
`define INDEXED_ORDERED_LIST_UNIT_DEFINES_SVH

// same-cycle implication
`define IOLU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IOLU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/iolu_pkg.sv
// Shared types and constants for the indexed ordered list unit.
// No dependencies.
package iolu_pkg;

  localparam int CAPACITY   = 32;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // fixed field widths of the channels
  localparam int MODE_W   = 3;
  localparam int POS_W    = 8;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int OUTCNT_W = 6;

  localparam logic [MODE_W-1:0] MODE_PUSH_HEAD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_TAIL = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_HEAD  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_TAIL  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_REMOVE    = 3'd5;
  localparam logic [MODE_W-1:0] MODE_FIND      = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL
  } cell_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t               op;
    logic [IDX_W-1:0]       pos;
    logic [CNT_W-1:0]       count;
    logic [DATA_WIDTH-1:0]  value;
  } cell_cmd_t;

endpackage

>>> sv/iolu_if.sv
// Request and result channel interfaces for the indexed ordered list unit.
// Depends on iolu_pkg.
interface iolu_in_if;
  logic                        valid;
  logic                        ready;
  logic [iolu_pkg::MODE_W-1:0] mode;
  logic [iolu_pkg::POS_W-1:0]  position;
  logic [iolu_pkg::VAL_W-1:0]  value;

  modport source (output valid, mode, position, value, input ready);
  modport sink   (input valid, mode, position, value, output ready);
endinterface

interface iolu_out_if;
  logic                          valid;
  logic                          ready;
  logic [iolu_pkg::STATUS_W-1:0] status;
  logic [iolu_pkg::OUTCNT_W-1:0] found_at;
  logic [iolu_pkg::VAL_W-1:0]    front_value;
  logic [iolu_pkg::VAL_W-1:0]    back_value;
  logic [iolu_pkg::OUTCNT_W-1:0] count;
  logic                          is_empty;

  modport source (output valid, status, found_at, front_value, back_value, count, is_empty,
                  input ready);
  modport sink   (input valid, status, found_at, front_value, back_value, count, is_empty,
                  output ready);
endinterface

>>> sv/iolu_cell.sv
// One storage cell of the list chain: holds one entry, shifts with its neighbors.
// Depends on iolu_pkg.
module iolu_cell (
  input  logic                            clk,
  input  logic [iolu_pkg::IDX_W-1:0]      idx,
  input  iolu_pkg::cell_cmd_t             cmd,
  input  logic [iolu_pkg::DATA_WIDTH-1:0] left_d,
  input  logic [iolu_pkg::DATA_WIDTH-1:0] right_d,
  output logic [iolu_pkg::DATA_WIDTH-1:0] d,
  output logic                            match
);
  import iolu_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  live;

  assign live  = CNT_W'(idx) < cmd.count;
  assign match = live && (data_r == cmd.value);
  assign d     = data_r;

  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      OP_INS: begin
        if (idx > cmd.pos) begin
          data_nxt = left_d;
        end else if (idx == cmd.pos) begin
          data_nxt = cmd.value;
        end
      end
      OP_DEL: begin
        if (idx >= cmd.pos) begin
          data_nxt = right_d;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

>>> sv/indexed_ordered_list_unit.sv
// Top level of the indexed ordered list unit: request decode, cell chain, result register.
// Depends on iolu_pkg, iolu_if, iolu_cell and indexed_ordered_list_unit_defines.svh.
//
//  channel | dir | word
//  in_ch   | in  | mode, position, value
//  out_ch  | out | status, found_at, front_value, back_value, count, is_empty
//
// Per request, the accept edge decodes status/find and shifts the cells of an insert
// or delete; the next edge reads front and back from the chain into the result register.
// A new request is taken once the previous result is gone or leaves in that cycle.
// rst_n (synchronous) clears the count and the handshake state; cell data is not reset.
// A stalled out_ch holds its word and blocks in_ch.
`include "indexed_ordered_list_unit_defines.svh"

module indexed_ordered_list_unit (
  input  logic       clk,
  input  logic       rst_n,
  iolu_in_if.sink    in_ch,
  iolu_out_if.source out_ch
);
  import iolu_pkg::*;

  logic [DATA_WIDTH-1:0] cell_d [CAPACITY];
  logic [CAPACITY-1:0]   cell_match;

  logic                  busy_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r;
  logic [OUTCNT_W-1:0]   out_found_r;
  logic [VAL_W-1:0]      out_front_r;
  logic [VAL_W-1:0]      out_back_r;
  logic [OUTCNT_W-1:0]   out_count_r;
  logic                  out_empty_r;

  logic                  acc;
  logic                  full;
  logic                  empty;
  logic                  pos_lt_cnt;
  logic [IDX_W-1:0]      ins_pos;
  logic [DATA_WIDTH-1:0] in_val;
  cell_op_t              op;
  logic [IDX_W-1:0]      op_pos;
  logic [STATUS_W-1:0]   status;
  logic [CNT_W-1:0]      found;
  cell_cmd_t             cmd;

  assign in_ch.ready = !busy_r && (!out_valid_r || out_ch.ready);
  assign acc         = in_ch.valid && in_ch.ready;

  assign full       = cnt_r == CNT_W'(CAPACITY);
  assign empty      = cnt_r == '0;
  assign pos_lt_cnt = 32'(in_ch.position) < 32'(cnt_r);
  assign ins_pos    = pos_lt_cnt ? IDX_W'(in_ch.position) : IDX_W'(cnt_r);
  assign in_val     = in_ch.value[DATA_WIDTH-1:0];

  // first live match wins; no match reports the count
  always_comb begin
    found = cnt_r;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cell_match[i]) found = CNT_W'(i);
    end
  end

  always_comb begin
    op      = OP_HOLD;
    op_pos  = '0;
    status  = ST_OK;
    cnt_nxt = cnt_r;
    case (in_ch.mode)
      MODE_PUSH_HEAD, MODE_PUSH_TAIL, MODE_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          op      = OP_INS;
          cnt_nxt = cnt_r + 1'b1;
          if (in_ch.mode == MODE_PUSH_TAIL) op_pos = IDX_W'(cnt_r);
          else if (in_ch.mode == MODE_INSERT) op_pos = ins_pos;
        end
      end
      MODE_POP_HEAD, MODE_POP_TAIL: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
          if (in_ch.mode == MODE_POP_HEAD) op = OP_DEL;
        end
      end
      MODE_REMOVE: begin
        if (!pos_lt_cnt) begin
          status = ST_RANGE;
        end else begin
          op      = OP_DEL;
          op_pos  = IDX_W'(in_ch.position);
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: status = ST_OK;
    endcase
  end

  assign cmd.op    = acc ? op : OP_HOLD;
  assign cmd.pos   = op_pos;
  assign cmd.count = cnt_r;
  assign cmd.value = in_val;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;
    if (g == 0) begin : g_head
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_d[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_d = cell_d[g];
    end else begin : g_mid_r
      assign right_d = cell_d[g+1];
    end
    iolu_cell u_cell (
      .clk     (clk),
      .idx     (IDX_W'(g)),
      .cmd     (cmd),
      .left_d  (left_d),
      .right_d (right_d),
      .d       (cell_d[g]),
      .match   (cell_match[g])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (busy_r) out_valid_nxt = 1'b1;
    else if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= acc;
      out_valid_r <= out_valid_nxt;
      if (acc) cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_status_r <= status;
      out_found_r  <= (in_ch.mode == MODE_FIND) ? OUTCNT_W'(found) : '0;
    end
    // cnt_r already holds the post-step count here
    if (busy_r) begin
      out_front_r <= empty ? '0 : VAL_W'(cell_d[0]);
      out_back_r  <= empty ? '0 : VAL_W'(cell_d[IDX_W'(cnt_r - 1'b1)]);
      out_count_r <= OUTCNT_W'(cnt_r);
      out_empty_r <= empty;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found_at    = out_found_r;
  assign out_ch.front_value = out_front_r;
  assign out_ch.back_value  = out_back_r;
  assign out_ch.count       = out_count_r;
  assign out_ch.is_empty    = out_empty_r;

  `IOLU_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(CAPACITY), "count above capacity")
  `IOLU_ASSERT_NEXT(a_acc_busy, acc, busy_r && !in_ch.ready, "accept did not start a step")
  `IOLU_ASSERT_NEXT(a_busy_valid, busy_r, out_valid_r, "step finished without a result")
  `IOLU_ASSERT_NOW(a_empty_flag, out_valid_r, out_empty_r == (out_count_r == '0),
                   "empty flag disagrees with count")

endmodule

>>> dv/tb.sv
// Self-checking testbench for indexed_ordered_list_unit: a shadow list predicts every result word.
// Depends on iolu_pkg, iolu_if (iolu_in_if, iolu_out_if) and the unit's RTL.
`timescale 1ns / 100ps

module tb;
  import iolu_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int MAX_IDLE = 13;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 490;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OUTCNT_W-1:0] found_at;
    logic [VAL_W-1:0]    front_value;
    logic [VAL_W-1:0]    back_value;
    logic [OUTCNT_W-1:0] count;
    logic                is_empty;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n;

  iolu_in_if  in_ch();
  iolu_out_if out_ch();

  indexed_ordered_list_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  // shadow copy of the list
  logic [DATA_WIDTH-1:0] shadow_items [CAPACITY];
  int unsigned           shadow_len = 0;

  list_result_t pending_results[$];

  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int peak_len = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int finds_hit = 0;

  int tx_idle_max = MAX_IDLE;
  int rx_idle_max = MAX_IDLE;
  int tx_gap = 0;
  bit tx_valid_hi = 1'b0;
  int rx_hold_cycles = 0;

  function automatic void open_slot(int unsigned p, logic [DATA_WIDTH-1:0] v);
    for (int unsigned i = shadow_len; i > p; i--) shadow_items[i] = shadow_items[i-1];
    shadow_items[p] = v;
    shadow_len++;
  endfunction

  function automatic void close_slot(int unsigned p);
    for (int unsigned i = p; i + 1 < shadow_len; i++) shadow_items[i] = shadow_items[i+1];
    shadow_len--;
  endfunction

  function automatic list_result_t apply_list_request(logic [MODE_W-1:0] mode,
                                                      logic [POS_W-1:0] pos,
                                                      logic [VAL_W-1:0] val);
    list_result_t r;
    logic [DATA_WIDTH-1:0] v;
    bit full;
    bit empty;
    bit hit;
    v = val[DATA_WIDTH-1:0];
    full = shadow_len >= CAPACITY;
    empty = shadow_len == 0;
    hit = 1'b0;
    r = '0;
    r.status = ST_OK;
    case (mode)
      MODE_PUSH_HEAD: if (full) r.status = ST_FULL; else open_slot(0, v);
      MODE_PUSH_TAIL: if (full) r.status = ST_FULL; else open_slot(shadow_len, v);
      MODE_POP_HEAD:  if (empty) r.status = ST_EMPTY; else close_slot(0);
      MODE_POP_TAIL:  if (empty) r.status = ST_EMPTY; else shadow_len--;
      MODE_INSERT: begin
        if (full) r.status = ST_FULL;
        else open_slot((pos < shadow_len) ? pos : shadow_len, v);
      end
      MODE_REMOVE: if (pos >= shadow_len) r.status = ST_RANGE; else close_slot(pos);
      MODE_FIND: begin
        r.found_at = OUTCNT_W'(shadow_len);
        for (int unsigned i = 0; i < shadow_len; i++) begin
          if (!hit && shadow_items[i] == v) begin
            r.found_at = OUTCNT_W'(i);
            hit = 1'b1;
          end
        end
        if (hit) finds_hit++;
      end
      default: ;
    endcase
    if (shadow_len != 0) begin
      r.front_value = VAL_W'(shadow_items[0]);
      r.back_value  = VAL_W'(shadow_items[shadow_len-1]);
    end
    r.count = OUTCNT_W'(shadow_len);
    r.is_empty = (shadow_len == 0);
    status_seen[r.status]++;
    if (shadow_len > peak_len) peak_len = shadow_len;
    return r;
  endfunction

  // valid stays high after a handshake only when the next word follows at once
  task automatic send_word(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                           logic [VAL_W-1:0] val);
    if (tx_gap > 0) repeat (tx_gap) @(posedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.position <= pos;
    in_ch.value    <= val;
    tx_valid_hi = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.insert(pending_results.size(), apply_list_request(mode, pos, val));
    items_sent++;
    tx_gap = $urandom_range(0, tx_idle_max);
    if (tx_gap > 0) begin
      in_ch.valid <= 1'b0;
      tx_valid_hi = 1'b0;
    end
  endtask

  // sender pauses until every outstanding result is back
  task automatic wait_results_drained();
    if (tx_valid_hi) begin
      in_ch.valid <= 1'b0;
      tx_valid_hi = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_empty_list();
    send_word(MODE_POP_HEAD, 8'd0, 32'h0);
    send_word(MODE_POP_TAIL, 8'd0, 32'h0);
    send_word(MODE_REMOVE, 8'd0, 32'h0);
    send_word(MODE_FIND, 8'd0, 32'h0);
    send_word(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_basic_ops();
    send_word(MODE_PUSH_HEAD, 8'd0, 32'h0000_0000);
    send_word(MODE_PUSH_TAIL, 8'hFF, 32'hFFFF_FFFF);
    send_word(MODE_INSERT, 8'd0, 32'h8000_0001);     // lands at the front
    send_word(MODE_INSERT, 8'hFF, 32'h5A5A_A5A5);    // past the end: appends
    send_word(MODE_INSERT, 8'd2, 32'h0000_0001);
    send_word(MODE_FIND, 8'd0, 32'hFFFF_FFFF);
    send_word(MODE_FIND, 8'd0, 32'h1234_5678);       // absent: reports count
    send_word(MODE_REMOVE, 8'hFF, 32'h0);
    send_word(MODE_REMOVE, 8'd5, 32'h0);              // exactly count: out of range
    send_word(MODE_REMOVE, 8'd1, 32'h0);
    send_word(MODE_REMOVE, 8'd0, 32'h0);
    send_word(MODE_UNUSED, 8'd3, 32'h0);
    send_word(MODE_POP_TAIL, 8'd0, 32'h0);
    send_word(MODE_POP_HEAD, 8'd0, 32'h0);
    send_word(MODE_POP_HEAD, 8'd0, 32'h0);
    send_word(MODE_FIND, 8'd0, 32'h0);
  endtask

  task automatic test_full_list();
    logic [VAL_W-1:0] tail;
    while (shadow_len < CAPACITY) send_word(MODE_PUSH_TAIL, 8'($urandom), $urandom);
    tail = shadow_items[CAPACITY-1];
    send_word(MODE_PUSH_HEAD, 8'd0, $urandom);
    send_word(MODE_PUSH_TAIL, 8'd0, $urandom);
    send_word(MODE_INSERT, 8'd0, $urandom);
    send_word(MODE_INSERT, 8'hFF, $urandom);
    send_word(MODE_FIND, 8'd0, tail);
    send_word(MODE_REMOVE, 8'(CAPACITY), 32'h0);
    send_word(MODE_REMOVE, 8'(CAPACITY - 1), 32'h0);
    send_word(MODE_INSERT, 8'd200, 32'hC0DE_0001);   // refill via append
    while (shadow_len > 0) send_word($urandom_range(0, 1) ? MODE_POP_HEAD : MODE_POP_TAIL,
                                     8'($urandom), $urandom);
    send_word(MODE_POP_TAIL, 8'd0, 32'h0);
  endtask

  // receiver stalls for a long stretch; the block fills up and stops taking words
  task automatic test_backpressure();
    tx_idle_max = 0;
    rx_hold_cycles = 90;
    repeat (16) send_word($urandom_range(0, 1) ? MODE_PUSH_TAIL : MODE_FIND,
                          8'($urandom), $urandom_range(0, 3));
    tx_idle_max = MAX_IDLE;
  endtask

  task automatic random_request(int grow_pct);
    int pick;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    pick = $urandom_range(0, 99);
    if (pick < 15) mode = MODE_FIND;
    else if (pick < 18) mode = MODE_UNUSED;
    else if ($urandom_range(0, 99) < grow_pct) begin
      case ($urandom_range(0, 2))
        0:       mode = MODE_PUSH_HEAD;
        1:       mode = MODE_PUSH_TAIL;
        default: mode = MODE_INSERT;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       mode = MODE_POP_HEAD;
        1:       mode = MODE_POP_TAIL;
        default: mode = MODE_REMOVE;
      endcase
    end
    if ($urandom_range(0, 3) == 0) pos = 8'($urandom);
    else pos = 8'($urandom_range(0, shadow_len + 1));
    // a small pool of values gives duplicates, so first-match order gets tested
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0:       val = 32'h0;
        1:       val = 32'hFFFF_FFFF;
        2:       val = 32'h0000_0005;
        default: val = 32'h8000_0000;
      endcase
    end else begin
      val = $urandom;
    end
    if (mode == MODE_FIND && shadow_len != 0 && $urandom_range(0, 9) < 6)
      val = shadow_items[$urandom_range(0, shadow_len - 1)];
    send_word(mode, pos, val);
  endtask

  task automatic test_random();
    int grow_pct;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ((n / 50) % 3)
          0:       grow_pct = 80;
          1:       grow_pct = 20;
          default: grow_pct = 50;
        endcase
      end
      // one stretch runs back to back on both sides
      if (n == 200) begin
        tx_idle_max = 0;
        rx_idle_max = 0;
      end else if (n == 320) begin
        tx_idle_max = MAX_IDLE;
        rx_idle_max = MAX_IDLE;
      end
      if (n == 450) wait_results_drained();
      random_request(grow_pct);
    end
  endtask

  // result receiver: random ready gaps, plus an occasional long hold
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_cycles > 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        gap = $urandom_range(0, rx_idle_max);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin : check_results
    list_result_t got;
    list_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.status, out_ch.found_at, out_ch.front_value, out_ch.back_value,
             out_ch.count, out_ch.is_empty};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with nothing expected: st=%0d found=%0d front=%h",
                   $realtime, got.status, got.found_at, got.front_value);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        results_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch on result %0d", $realtime, results_checked);
            $display("  expected st=%0d found=%0d front=%h back=%h cnt=%0d empty=%0b",
                     want.status, want.found_at, want.front_value, want.back_value,
                     want.count, want.is_empty);
            $display("  actual   st=%0d found=%0d front=%h back=%h cnt=%0d empty=%0b",
                     got.status, got.found_at, got.front_value, got.back_value,
                     got.count, got.is_empty);
          end
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.mode     <= '0;
    in_ch.position <= '0;
    in_ch.value    <= '0;
    for (int i = 0; i < CAPACITY; i++) shadow_items[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    wait_results_drained();
    test_basic_ops();
    wait_results_drained();
    test_full_list();
    wait_results_drained();
    test_backpressure();
    wait_results_drained();
    test_random();
    wait_results_drained();

    $display("Covered %0d requests, %0d results checked, list peaked at %0d of %0d entries.",
             items_sent, results_checked, peak_len, CAPACITY);
    $display("Status ok/empty/full/range: %0d/%0d/%0d/%0d, finds with a match: %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], finds_hit);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding.", pending_results.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/iolu_pkg.sv
sv/iolu_if.sv
sv/iolu_cell.sv
sv/indexed_ordered_list_unit.sv
dv/tb.sv
